/* design/tracker_to_midi_translator_defines.svh */
// Assertion helpers used by the top design file.
`ifndef TRACKER_TO_MIDI_TRANSLATOR_DEFINES_SVH
`define TRACKER_TO_MIDI_TRANSLATOR_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define T2M_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("t2m: property violated");

// Condition must never be seen outside reset.
`define T2M_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("t2m: forbidden condition seen");

`endif

/* design/t2m_pkg.sv */
`default_nettype none

package t2m_pkg;

   localparam int IdleCountBits = 16;
   localparam int CmpBits       = (IdleCountBits > 16) ? IdleCountBits : 16;
   localparam int NumSlots      = 5;
   localparam int IdxBits       = $clog2(NumSlots);
   localparam int CntBits       = $clog2(NumSlots + 1);
   localparam int CsrAddrBits   = 3;
   localparam int CsrDataBits   = 16;
   localparam int NumTracks     = 4;

   localparam logic [IdleCountBits-1:0] MaxIdle = {IdleCountBits{1'b1}};

   typedef enum logic [CsrAddrBits-1:0] {
      CSR_CHANNEL_MAP     = 3'd0,
      CSR_NOTE_VELOCITY   = 3'd1,
      CSR_FEATURE_ENABLES = 3'd2,
      CSR_TRACK_MUTES     = 3'd3,
      CSR_GLOBAL_MUTE     = 3'd4,
      CSR_SOLO_VALUE      = 3'd5,
      CSR_STOP_IDLE_LIMIT = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_MESSAGE  = 2'd0,
      KIND_REALTIME = 2'd1,
      KIND_POLL     = 2'd2,
      KIND_RESERVED = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      GRP_NOTE    = 2'd0,
      GRP_CC      = 2'd1,
      GRP_PC      = 2'd2,
      GRP_IGNORED = 2'd3
   } cmd_group_type;

   // feature_enables bit positions
   localparam int FeatCc         = 0;
   localparam int FeatPc         = 1;
   localparam int FeatClock      = 2;
   localparam int FeatRealtime   = 3;
   localparam int FeatCorrection = 4;

   localparam logic [7:0] CmdBase      = 8'h70;
   localparam logic [7:0] RtStartByte  = 8'h7D;
   localparam logic [7:0] RtStopByte   = 8'h7E;
   localparam logic [7:0] RtIdleByte   = 8'h7F;
   localparam logic [7:0] PcClockValue = 8'h7F;
   localparam logic [6:0] VelocityRst  = 7'd100;
   localparam logic [15:0] IdleLimitRst = 16'd100;

   localparam logic [7:0] StatusClock   = 8'hF8;
   localparam logic [7:0] StatusStop    = 8'hFC;
   localparam logic [7:0] StatusStart   = 8'hFA;
   localparam logic [7:0] StatusNoteOn  = 8'h90;
   localparam logic [7:0] StatusNoteOff = 8'h80;
   localparam logic [7:0] StatusCc      = 8'hB0;
   localparam logic [7:0] StatusPc      = 8'hC0;
   localparam logic [7:0] CcController  = 8'h01;

   localparam logic [3:0] CableNoteOff  = 4'd8;
   localparam logic [3:0] CableNoteOn   = 4'd9;
   localparam logic [3:0] CableCc       = 4'd11;
   localparam logic [3:0] CablePc       = 4'd12;
   localparam logic [3:0] CableRealtime = 4'd15;

   typedef struct packed {
      logic [15:0] channel_map;
      logic [6:0]  note_velocity;
      logic [4:0]  feature_enables;
      logic [3:0]  track_mutes;
      logic        global_mute;
      logic [2:0]  solo_value;
      logic [15:0] stop_idle_limit;
   } cfg_type;

   typedef struct packed {
      logic [NumTracks-1:0][7:0] held_note;
      logic                      start_seen;
      logic                      stop_pending;
      logic [IdleCountBits-1:0]  idle_count;
      logic [1:0]                previous_track;
   } state_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] code;
      logic [7:0] value;
   } req_item_type;

   typedef struct packed {
      logic [3:0] cable_code;
      logic [7:0] status_byte;
      logic [7:0] data_first;
      logic [7:0] data_second;
   } midi_msg_type;

   function automatic logic [3:0] chan_of(input logic [15:0] map, input logic [1:0] trk);
      return map[{trk, 2'b00} +: 4];
   endfunction

endpackage

`default_nettype wire

/* design/t2m_channels.sv */
`default_nettype none

interface t2m_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] code;
   logic [7:0] value;

   modport source (output valid, kind, code, value, input ready);
   modport sink   (input valid, kind, code, value, output ready);
endinterface

interface t2m_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] cable_code;
   logic [7:0] status_byte;
   logic [7:0] data_first;
   logic [7:0] data_second;
   logic       last_of_run;

   modport source (output valid, cable_code, status_byte, data_first, data_second,
                   last_of_run, input ready);
   modport sink   (input valid, cable_code, status_byte, data_first, data_second,
                   last_of_run, output ready);
endinterface

`default_nettype wire

/* design/t2m_engine.sv */
`default_nettype none

module t2m_engine
   import t2m_pkg::*;
(
   input  wire req_item_type                 item,
   input  wire cfg_type                      cfg,
   input  wire state_type                    st,
   output state_type                         nxt,
   output midi_msg_type [NumSlots-1:0]       msgs,
   output logic [CntBits-1:0]                msg_cnt
);

   midi_msg_type [NumSlots-1:0] cand;
   logic [NumSlots-1:0]         cand_v;
   logic [7:0]                  cmd;
   logic [1:0]                  trk;
   logic [1:0]                  play_trk;
   logic [7:0]                  play_note;
   logic                        do_play;
   logic [6:0]                  vel;
   logic                        rt_en;
   logic                        corr_ok;
   logic [CmpBits-1:0]          idle_ext;
   logic [CmpBits-1:0]          limit_ext;

   always_comb begin
      nxt       = st;
      cand      = '0;
      cand_v    = '0;
      do_play   = 1'b0;
      cmd       = item.code - CmdBase;
      trk       = cmd[1:0];
      play_trk  = trk;
      play_note = item.value;
      rt_en     = cfg.feature_enables[FeatRealtime];
      corr_ok   = cfg.feature_enables[FeatCorrection] && (item.value != 8'd0);
      idle_ext  = CmpBits'(st.idle_count);
      limit_ext = CmpBits'(cfg.stop_idle_limit);

      unique case (item.kind)
         KIND_MESSAGE: begin
            nxt.idle_count   = '0;
            nxt.stop_pending = 1'b0;
            if (cmd[7:4] != 4'd0) begin
               nxt.previous_track = 2'd0;
            end else if (!cfg.track_mutes[trk]) begin
               nxt.previous_track = trk;
               unique case (cmd_group_type'(cmd[3:2]))
                  GRP_NOTE: begin
                     do_play = 1'b1;
                  end
                  GRP_CC: begin
                     if (cfg.feature_enables[FeatCc]) begin
                        cand_v[0] = 1'b1;
                        cand[0]   = '{CableCc, StatusCc | {4'd0, chan_of(cfg.channel_map, trk)},
                                      CcController, item.value};
                     end else if (corr_ok) begin
                        do_play  = 1'b1;
                        play_trk = st.previous_track;
                     end
                  end
                  GRP_PC: begin
                     if (item.value == PcClockValue) begin
                        if (cfg.feature_enables[FeatClock]) begin
                           cand_v[0] = 1'b1;
                           cand[0]   = '{CableRealtime, StatusClock, 8'd0, 8'd0};
                        end
                     end else if (cfg.feature_enables[FeatPc]) begin
                        cand_v[0] = 1'b1;
                        cand[0]   = '{CablePc, StatusPc | {4'd0, chan_of(cfg.channel_map, trk)},
                                      item.value, 8'd0};
                     end else if (corr_ok) begin
                        do_play  = 1'b1;
                        play_trk = st.previous_track;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         KIND_REALTIME: begin
            priority if (item.code == RtStartByte) begin
               if (rt_en && !st.start_seen) begin
                  cand_v[0]        = 1'b1;
                  cand[0]          = '{CableRealtime, StatusStart, 8'd0, 8'd0};
                  nxt.start_seen   = 1'b1;
                  nxt.stop_pending = 1'b0;
               end
            end else if (item.code == RtStopByte) begin
               if (rt_en) nxt.stop_pending = 1'b1;
            end else if (item.code == RtIdleByte) begin
               if (st.stop_pending && st.idle_count != MaxIdle)
                  nxt.idle_count = st.idle_count + 1'b1;
            end else begin
            end
         end
         KIND_POLL: begin
            if (st.stop_pending && idle_ext > limit_ext) begin
               if (rt_en) begin
                  cand_v[0] = 1'b1;
                  cand[0]   = '{CableRealtime, StatusStop, 8'd0, 8'd0};
               end
               for (int t = 0; t < NumTracks; t++) begin
                  if (st.held_note[t] != 8'd0) begin
                     cand_v[t+1] = 1'b1;
                     cand[t+1]   = '{CableNoteOff,
                                     StatusNoteOff | {4'd0, chan_of(cfg.channel_map, 2'(t))},
                                     st.held_note[t], 8'd0};
                  end
               end
               nxt.held_note    = '0;
               nxt.start_seen   = 1'b0;
               nxt.stop_pending = 1'b0;
               nxt.idle_count   = '0;
            end
         end
         default: begin
         end
      endcase

      // note play: off for the held note if there is one, then on unless the new note is zero
      vel = cfg.note_velocity;
      if ((cfg.solo_value != 3'd0 && {1'b0, play_trk} != cfg.solo_value) || cfg.global_mute)
         vel = 7'd0;
      if (do_play) begin
         if (st.held_note[play_trk] != 8'd0) begin
            cand_v[0] = 1'b1;
            cand[0]   = '{CableNoteOff,
                          StatusNoteOff | {4'd0, chan_of(cfg.channel_map, play_trk)},
                          st.held_note[play_trk], 8'd0};
         end
         if (play_note != 8'd0) begin
            cand_v[1] = 1'b1;
            cand[1]   = '{CableNoteOn,
                          StatusNoteOn | {4'd0, chan_of(cfg.channel_map, play_trk)},
                          play_note, {1'b0, vel}};
         end
         nxt.held_note[play_trk] = play_note;
      end
   end

   // pack the valid slots in order
   always_comb begin
      msgs    = '0;
      msg_cnt = '0;
      for (int i = 0; i < NumSlots; i++) begin
         if (cand_v[i]) begin
            msgs[msg_cnt[IdxBits-1:0]] = cand[i];
            msg_cnt = msg_cnt + 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

/* design/t2m_rsp_queue.sv */
`default_nettype none

module t2m_rsp_queue
   import t2m_pkg::*;
(
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               load,
   input  wire midi_msg_type [NumSlots-1:0]  load_msgs,
   input  wire [CntBits-1:0]                 load_cnt,
   input  wire                               pop,
   output midi_msg_type                      head,
   output logic [CntBits-1:0]                cnt
);

   midi_msg_type [NumSlots-1:0] q_ff, q_in;
   logic [CntBits-1:0]          cnt_ff, cnt_in;

   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      priority if (load) begin
         q_in   = load_msgs;
         cnt_in = load_cnt;
      end else if (pop) begin
         for (int i = 0; i < NumSlots - 1; i++) q_in[i] = q_ff[i+1];
         cnt_in = cnt_ff - 1'b1;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign head = q_ff[0];
   assign cnt  = cnt_ff;

endmodule

`default_nettype wire

/* design/tracker_to_midi_translator.sv */
// Path: a request waits in the input register until the result queue is empty or is
//   handing over its last message; the engine then loads the request's MIDI messages
//   into the result queue register, whose head drives rsp.
// Throughput: one request per cycle while rsp is ready and each makes at most one
//   message; a request that makes N messages (N = 0..5) holds the queue for N handshakes.
// Reset: synchronous, active high; clears the held notes, transport flags, idle count,
//   previous track, queue and restores register defaults (velocity and stop limit 100).
`default_nettype none

`include "tracker_to_midi_translator_defines.svh"

module tracker_to_midi_translator
   import t2m_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   t2m_req_if.sink                 req_chan,
   t2m_rsp_if.source               rsp_chan,
   input  wire                     csr_we,
   input  wire [CsrAddrBits-1:0]   csr_index,
   input  wire [CsrDataBits-1:0]   csr_wdata
);

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   // input register: one request waiting for the engine
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;

   // translator state (held notes, transport flags, idle count)
   state_type state_ff, state_nxt;

   midi_msg_type [NumSlots-1:0] eng_msgs;
   logic [CntBits-1:0]          eng_cnt;
   midi_msg_type                q_head;
   logic [CntBits-1:0]          q_cnt;
   logic                        advance;
   logic                        req_fire;
   logic                        rsp_fire;
   logic                        q_load;
   logic                        q_drain_last;

   // The engine may retire the waiting request once the queue is empty or is
   // handing over its last message this very cycle.
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign advance  = in_valid_ff && ((q_cnt == '0) || (q_cnt == CntBits'(1) && rsp_chan.ready));
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;

   // queue loads only when the retiring request made messages
   assign q_load       = advance && (eng_cnt != '0);
   assign q_drain_last = rsp_fire && (q_cnt == CntBits'(1)) && !in_valid_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_item_in  = '{kind_type'(req_chan.kind), req_chan.code, req_chan.value};
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // register writes; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CHANNEL_MAP:     cfg_in.channel_map     = csr_wdata;
            CSR_NOTE_VELOCITY:   cfg_in.note_velocity   = csr_wdata[6:0];
            CSR_FEATURE_ENABLES: cfg_in.feature_enables = csr_wdata[4:0];
            CSR_TRACK_MUTES:     cfg_in.track_mutes     = csr_wdata[3:0];
            CSR_GLOBAL_MUTE:     cfg_in.global_mute     = csr_wdata[0];
            CSR_SOLO_VALUE:      cfg_in.solo_value      = csr_wdata[2:0];
            CSR_STOP_IDLE_LIMIT: cfg_in.stop_idle_limit = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
         cfg_ff      <= '{16'd0, VelocityRst, 5'd0, 4'd0, 1'b0, 3'd0, IdleLimitRst};
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         cfg_ff      <= cfg_in;
         if (advance) state_ff <= state_nxt;
      end
   end

   // all the decoding for one request: messages out and next state
   t2m_engine u_engine (
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .st      (state_ff),
      .nxt     (state_nxt),
      .msgs    (eng_msgs),
      .msg_cnt (eng_cnt)
   );

   // result queue: holds up to five messages, drains one per handshake
   t2m_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (q_load),
      .load_msgs (eng_msgs),
      .load_cnt  (eng_cnt),
      .pop       (rsp_fire),
      .head      (q_head),
      .cnt       (q_cnt)
   );

   assign rsp_chan.valid       = (q_cnt != '0);
   assign rsp_chan.cable_code  = q_head.cable_code;
   assign rsp_chan.status_byte = q_head.status_byte;
   assign rsp_chan.data_first  = q_head.data_first;
   assign rsp_chan.data_second = q_head.data_second;
   assign rsp_chan.last_of_run = (q_cnt == CntBits'(1));

   // queue never holds more than one request's worth of messages
   `T2M_ASSERT_NEVER(a_queue_bound, clock, reset, q_cnt > CntBits'(NumSlots))
   // a loaded queue holds exactly the engine's message count
   `T2M_ASSERT(a_load_count, clock, reset, q_load |=> (q_cnt == $past(eng_cnt)))
   // draining the last message with nothing waiting leaves the output idle
   `T2M_ASSERT(a_drain_idle, clock, reset, q_drain_last |=> !rsp_chan.valid)

endmodule

`default_nettype wire
